// ----- rtl/rbhd_pkg.sv -----
// Shared types and constants for the RLE / bit-packed hybrid decoder.
// No dependencies.
package rbhd_pkg;

  localparam int MAX_WIDTH = 32;

  localparam logic [1:0] PH_HDR = 2'd0;
  localparam logic [1:0] PH_PK  = 2'd1;
  localparam logic [1:0] PH_RLE = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_EMPTY_PK = 3'd1;
  localparam logic [2:0] ERR_EMPTY_RL = 3'd2;
  localparam logic [2:0] ERR_WIDE     = 3'd3;
  localparam logic [2:0] ERR_HDR_LONG = 3'd4;

  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  // One queue entry: cnt results unpacked from bits, w bits each, lsb first.
  // fin applies to the last of them.
  typedef struct packed {
    logic [38:0] bits;
    logic [5:0]  w;
    logic [3:0]  cnt;
    logic [30:0] rep;
    logic [2:0]  err;
    logic        fin;
  } desc_t;

endpackage

// ----- rtl/rbhd_front.sv -----
// Front end: config registers, header / run parsing, one byte per cycle
// unless q_full. Emits up to one rbhd_pkg::desc_t a byte. Uses rbhd_pkg.
module rbhd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_idx,
  input  logic [30:0]       cfg_wdata,
  input  logic              in_valid,
  input  logic [7:0]        in_data_byte,
  input  logic              in_end_of_payload,
  input  logic              q_full,
  output logic              push,
  output rbhd_pkg::desc_t   desc
);

  logic [5:0]  vw_r;
  logic [30:0] vc_r;

  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [3:0]  hb_r, hb_nxt;
  logic [31:0] pbl_r, pbl_nxt;
  logic [38:0] bbuf_r, bbuf_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [31:0] pvl_r, pvl_nxt;
  logic [31:0] rv_r, rv_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [30:0] rlen_r, rlen_nxt;
  logic [30:0] emit_r, emit_nxt;
  logic        stop_r, stop_nxt;

  logic        acc_in;
  logic [5:0]  w;
  logic [2:0]  nbytes;
  logic [30:0] room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vw_r <= 6'd1;
      vc_r <= 31'd0;
    end else if (cfg_we) begin
      if (cfg_idx == rbhd_pkg::REG_WIDTH) begin
        vw_r <= cfg_wdata[5:0];
      end else begin
        vc_r <= cfg_wdata;
      end
    end
  end

  assign acc_in = in_valid && !q_full;
  assign w      = (vw_r == 6'd0) ? 6'd1 :
                  (vw_r > 6'(rbhd_pkg::MAX_WIDTH)) ? 6'(rbhd_pkg::MAX_WIDTH) : vw_r;
  assign nbytes = 3'((7'(w) + 7'd7) >> 3);
  assign room   = vc_r - emit_r;

  always_comb begin
    logic [63:0] hsh;
    logic [5:0]  hamt;
    logic [30:0] len;
    logic [33:0] len8;
    logic [36:0] lenw;
    logic [38:0] bx;
    logic [5:0]  fx;
    logic [3:0]  kraw;
    logic [3:0]  k;
    logic [8:0]  kw;
    logic [31:0] rvx;
    logic [30:0] rep;

    phase_nxt = phase_r; acc_nxt = acc_r; hb_nxt = hb_r; pbl_nxt = pbl_r;
    bbuf_nxt = bbuf_r; fill_nxt = fill_r; pvl_nxt = pvl_r; rv_nxt = rv_r;
    idx_nxt = idx_r; rlen_nxt = rlen_r; emit_nxt = emit_r; stop_nxt = stop_r;
    push = 1'b0;
    desc = '0;
    desc.w = 6'(rbhd_pkg::MAX_WIDTH);
    desc.cnt = 4'd1;
    desc.fin = 1'b1;
    hamt = 6'(hb_r[2:0]) * 6'd7;
    hsh  = {57'd0, in_data_byte[6:0]} << hamt;
    len  = 31'd0; len8 = '0; lenw = '0;
    bx   = bbuf_r | ({31'd0, in_data_byte} << fill_r);
    fx   = fill_r + 6'd8;
    kraw = 4'd0; k = 4'd0; kw = 9'd0;
    rvx  = rv_r | ({24'd0, in_data_byte} << {idx_r, 3'b000});
    rep  = 31'd0;

    if (acc_in) begin
      if (stop_r) begin
        // discard until end of payload
      end else if (emit_r >= vc_r) begin
        push = 1'b1;
        stop_nxt = 1'b1;
      end else begin
        case (phase_r)
          rbhd_pkg::PH_HDR: begin
            acc_nxt = acc_r | hsh[31:0];
            hb_nxt  = hb_r + 4'd1;
            if (in_data_byte[7]) begin
              if (hb_nxt >= 4'd5) begin
                push = 1'b1;
                desc.err = rbhd_pkg::ERR_HDR_LONG;
                stop_nxt = 1'b1;
              end
            end else begin
              len = acc_nxt[31:1];
              if (acc_nxt[0]) begin
                if (len == 31'd0) begin
                  push = 1'b1;
                  desc.err = rbhd_pkg::ERR_EMPTY_PK;
                  stop_nxt = 1'b1;
                end else begin
                  len8 = {len, 3'b000};
                  lenw = {6'd0, len} * {31'd0, w};
                  pvl_nxt = (len8[33:32] != 2'd0) ? 32'hFFFF_FFFF : len8[31:0];
                  pbl_nxt = (lenw[36:32] != 5'd0) ? 32'hFFFF_FFFF : lenw[31:0];
                  bbuf_nxt = '0;
                  fill_nxt = '0;
                  phase_nxt = rbhd_pkg::PH_PK;
                end
              end else begin
                if (len == 31'd0) begin
                  push = 1'b1;
                  desc.err = rbhd_pkg::ERR_EMPTY_RL;
                  stop_nxt = 1'b1;
                end else begin
                  rlen_nxt = len;
                  rv_nxt = '0;
                  idx_nxt = '0;
                  phase_nxt = rbhd_pkg::PH_RLE;
                end
              end
              acc_nxt = '0;
              hb_nxt = '0;
            end
          end
          rbhd_pkg::PH_PK: begin
            if (pbl_r != 32'd0) pbl_nxt = pbl_r - 32'd1;
            // whole values held in the buffer: largest j <= 8 with j*w <= fx
            for (int j = 1; j <= 8; j++) begin
              if ({3'd0, fx} >= 9'(j) * {3'd0, w}) kraw = 4'(j);
            end
            k = kraw;
            if (pvl_r < {28'd0, k}) k = pvl_r[3:0];
            if (room < {27'd0, k}) k = room[3:0];
            kw = {5'd0, k} * {3'd0, w};
            bbuf_nxt = bx >> kw;
            fill_nxt = fx - kw[5:0];
            pvl_nxt  = pvl_r - {28'd0, k};
            if (k != 4'd0) begin
              push = 1'b1;
              desc.bits = bx;
              desc.w = w;
              desc.cnt = k;
              desc.rep = 31'd1;
              desc.fin = ({27'd0, k} == room);
              emit_nxt = emit_r + {27'd0, k};
              stop_nxt = desc.fin;
            end
            if (pvl_nxt == 32'd0) begin
              bbuf_nxt = '0;
              fill_nxt = '0;
            end
            if (pbl_nxt == 32'd0) begin
              phase_nxt = rbhd_pkg::PH_HDR;
              bbuf_nxt = '0;
              fill_nxt = '0;
              pvl_nxt = '0;
            end
          end
          rbhd_pkg::PH_RLE: begin
            rv_nxt = rvx;
            if ({1'b0, idx_r} + 3'd1 >= nbytes) begin
              phase_nxt = rbhd_pkg::PH_HDR;
              idx_nxt = '0;
              push = 1'b1;
              if ((rvx >> w) != 32'd0) begin
                desc.err = rbhd_pkg::ERR_WIDE;
                stop_nxt = 1'b1;
              end else begin
                rep = (rlen_r < room) ? rlen_r : room;
                emit_nxt = emit_r + rep;
                desc.bits = {7'd0, rvx};
                desc.rep = rep;
                desc.fin = (rep == room);
                stop_nxt = desc.fin;
              end
            end else begin
              idx_nxt = idx_r + 2'd1;
            end
          end
          default: begin
            phase_nxt = rbhd_pkg::PH_HDR;
          end
        endcase
        if (in_end_of_payload && !stop_nxt) begin
          if (push) begin
            desc.fin = 1'b1;
          end else begin
            push = 1'b1;
            desc = '0;
            desc.w = 6'(rbhd_pkg::MAX_WIDTH);
            desc.cnt = 4'd1;
            desc.fin = 1'b1;
          end
        end
      end
      if (in_end_of_payload) begin
        phase_nxt = rbhd_pkg::PH_HDR; acc_nxt = '0; hb_nxt = '0; pbl_nxt = '0;
        bbuf_nxt = '0; fill_nxt = '0; pvl_nxt = '0; rv_nxt = '0; idx_nxt = '0;
        rlen_nxt = '0; emit_nxt = '0; stop_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rbhd_pkg::PH_HDR;
      acc_r   <= '0;
      hb_r    <= '0;
      pbl_r   <= '0;
      bbuf_r  <= '0;
      fill_r  <= '0;
      pvl_r   <= '0;
      rv_r    <= '0;
      idx_r   <= '0;
      rlen_r  <= '0;
      emit_r  <= '0;
      stop_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      hb_r    <= hb_nxt;
      pbl_r   <= pbl_nxt;
      bbuf_r  <= bbuf_nxt;
      fill_r  <= fill_nxt;
      pvl_r   <= pvl_nxt;
      rv_r    <= rv_nxt;
      idx_r   <= idx_nxt;
      rlen_r  <= rlen_nxt;
      emit_r  <= emit_nxt;
      stop_r  <= stop_nxt;
    end
  end

endmodule

// ----- rtl/rbhd_back.sv -----
// Back end: descriptor queue and result unpacker with output register.
// One result beat per cycle while out_stall is low. Uses rbhd_pkg.
module rbhd_back #(
  parameter int QDEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rbhd_pkg::desc_t   desc,
  output logic              q_full,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_value,
  output logic [30:0]       out_repeat_res,
  output logic              out_final_res,
  output logic [2:0]        out_error
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  rbhd_pkg::desc_t q_r [QDEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [PW:0]     cnt_r, cnt_nxt;

  rbhd_pkg::desc_t cur_r, cur_nxt, src;
  logic [3:0]      left_r, left_nxt, src_left;
  logic            have_cur, src_ok, adv, pop;

  logic            ov_r, ov_nxt;
  logic [31:0]     val_r, val_nxt, vmask;
  logic [30:0]     rep_r, rep_nxt;
  logic            fin_r, fin_nxt;
  logic [2:0]      err_r, err_nxt;

  assign q_full   = (cnt_r == (PW+1)'(QDEPTH));
  assign have_cur = (left_r != 4'd0);
  assign src      = have_cur ? cur_r : q_r[rp_r];
  assign src_left = have_cur ? left_r : q_r[rp_r].cnt;
  assign src_ok   = have_cur || (cnt_r != '0);
  assign adv      = !ov_r || !out_stall;
  assign pop      = adv && src_ok && !have_cur;
  assign vmask    = (src.w >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << src.w) - 32'd1);

  always_comb begin
    cur_nxt  = cur_r;
    left_nxt = left_r;
    ov_nxt   = ov_r;
    val_nxt  = val_r;
    rep_nxt  = rep_r;
    fin_nxt  = fin_r;
    err_nxt  = err_r;
    if (adv) begin
      ov_nxt = src_ok;
      if (src_ok) begin
        val_nxt  = src.bits[31:0] & vmask;
        rep_nxt  = src.rep;
        err_nxt  = src.err;
        fin_nxt  = src.fin && (src_left == 4'd1);
        cur_nxt  = src;
        cur_nxt.bits = src.bits >> src.w;
        left_nxt = src_left - 4'd1;
      end
    end
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      cnt_r  <= '0;
      left_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(QDEPTH - 1)) ? '0 : wp_r + PW'(1);
      if (pop)  rp_r <= (rp_r == PW'(QDEPTH - 1)) ? '0 : rp_r + PW'(1);
      cnt_r  <= cnt_nxt;
      left_r <= left_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    val_r <= val_nxt;
    rep_r <= rep_nxt;
    fin_r <= fin_nxt;
    err_r <= err_nxt;
  end

  assign out_valid      = ov_r;
  assign out_value      = val_r;
  assign out_repeat_res = rep_r;
  assign out_final_res  = fin_r;
  assign out_error      = err_r;

endmodule

// ----- rtl/rle_bitpack_hybrid_decoder_unit.sv -----
// Top level of the RLE / bit-packed hybrid decoder.
// Instantiates rbhd_front and rbhd_back; uses rbhd_pkg.
//
//   channel | ports                                        | dir
//   in      | in_valid in_stall in_data_byte in_end_of_payload | byte beats in
//   out     | out_valid out_stall out_value out_repeat_res ... | result beats out
//   cfg     | cfg_we cfg_idx cfg_wdata                     | register writes
//
// The front parses one byte per cycle while the queue is not full; the back emits
// one result beat per cycle while out_stall is low. A byte of a packed run gives
// up to 8 results (w=1). Results pass through the queue and then the output register.
// in_stall rises only when the QDEPTH-entry queue is full; rst_n is synchronous.
module rle_bitpack_hybrid_decoder_unit #(
  parameter int QDEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [30:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_value,
  output logic [30:0] out_repeat_res,
  output logic        out_final_res,
  output logic [2:0]  out_error
);

  logic            push, q_full;
  rbhd_pkg::desc_t desc;

  rbhd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_data_byte     (in_data_byte),
    .in_end_of_payload(in_end_of_payload),
    .q_full           (q_full),
    .push             (push),
    .desc             (desc)
  );

  rbhd_back #(.QDEPTH(QDEPTH)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .desc          (desc),
    .q_full        (q_full),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .out_repeat_res(out_repeat_res),
    .out_final_res (out_final_res),
    .out_error     (out_error)
  );

  assign in_stall = q_full;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full) else $error("queue push while full");

  a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error != rbhd_pkg::ERR_NONE) |-> (out_final_res && out_value == 32'd0))
    else $error("error beat not final or nonzero value");

  a_zero_rep_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_repeat_res == 31'd0) |-> out_final_res)
    else $error("zero repeat on non-final beat");
`endif

endmodule
